>>> hw/rtl/protobuf_wire_stream_parser_assert.svh
// Assertion macros shared by the wire stream parser modules.
`ifndef PROTOBUF_WIRE_STREAM_PARSER_ASSERT_SVH
`define PROTOBUF_WIRE_STREAM_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PWSP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PWSP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/pwsp_pkg.sv
// Types and codes of the protobuf wire stream parser.
package pwsp_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       final_byte;
	} pwsp_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [28:0] field_id;
		logic [2:0]  wire_kind;
		logic [63:0] payload_value;
		logic [2:0]  error_code;
		logic        message_end;
	} pwsp_out_t;

	localparam logic [1:0] KIND_SCALAR  = 2'd0;
	localparam logic [1:0] KIND_HEADER  = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_GROUP     = 3'd1;
	localparam logic [2:0] ERR_UNKNOWN   = 3'd2;
	localparam logic [2:0] ERR_TRUNCATED = 3'd3;
	localparam logic [2:0] ERR_TOO_LONG  = 3'd4;
	localparam logic [2:0] ERR_LEN_LARGE = 3'd5;

	localparam logic [2:0] WIRE_VARINT  = 3'd0;
	localparam logic [2:0] WIRE_FIX64   = 3'd1;
	localparam logic [2:0] WIRE_LEN     = 3'd2;
	localparam logic [2:0] WIRE_SGROUP  = 3'd3;
	localparam logic [2:0] WIRE_EGROUP  = 3'd4;
	localparam logic [2:0] WIRE_FIX32   = 3'd5;

	localparam logic [3:0] TAG_LAST_POS    = 4'd4;
	localparam logic [3:0] VARINT_LAST_POS = 4'd9;
	localparam logic [3:0] LEN_DATA_POS    = 4'd5;

endpackage

>>> hw/rtl/protobuf_wire_stream_parser.sv
// Protobuf wire stream parser: top level with input and result registers.
// Byte channel: byte_valid/byte_ready/byte_data carry one message byte per beat,
// final_byte marking the last byte of a message.
// Result channel: res_valid/res_ready/res_data carry decoded beats: scalar
// fields, bytes headers with the length, payload bytes, and error beats.
// A byte beat produces zero or one result beat; tag bytes produce only error
// beats, and dropped bytes produce none.
// A taken byte is held in the input register, and its result, if any, is then
// registered in the result register, from which the receiver takes it.
// Throughput: one byte per cycle while results are drained; the decode of
// each byte is a single pass through the input register's logic.
// When the result receiver stalls, the held result stays put, the input
// register still advances on bytes that produce no result, and byte_ready
// drops once a byte that needs the result slot is waiting.
// Reset clears both registers' valid flags and returns the decoder to
// expecting a tag; a final byte returns the decoder there too at message end.
`include "protobuf_wire_stream_parser_assert.svh"

module protobuf_wire_stream_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  pwsp_pkg::pwsp_in_t  byte_data,
	output logic                res_valid,
	input  logic                res_ready,
	output pwsp_pkg::pwsp_out_t res_data
);
	import pwsp_pkg::*;

	logic      valid_s1;
	pwsp_in_t  item_s1;
	logic      res_valid_q;
	pwsp_out_t res_q;
	logic      have;
	pwsp_out_t result;
	logic      adv;

	assign adv        = valid_s1 && (!have || !res_valid_q || res_ready);
	assign byte_ready = !valid_s1 || adv;
	assign res_valid  = res_valid_q;
	assign res_data   = res_q;

	pwsp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.have   (have),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (byte_ready) valid_s1 <= byte_valid;
			if (adv && have) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) item_s1 <= byte_data;
		if (adv && have) res_q <= result;
	end

	`PWSP_ASSERT_IMP(a_no_overwrite, adv && have, !res_valid_q || res_ready,
		"result register overwritten while held")
	`PWSP_ASSERT_IMP(a_err_value_zero, res_valid_q && res_q.kind == KIND_ERROR,
		res_q.payload_value == 64'd0 && res_q.error_code != ERR_NONE,
		"error beat with value or without code")
	`PWSP_ASSERT_IMP(a_ok_no_code, res_valid_q && res_q.kind != KIND_ERROR,
		res_q.error_code == ERR_NONE, "non-error beat carries an error code")

endmodule

>>> hw/rtl/pwsp_core.sv
// Decode state and per-beat next-state/result logic of the wire stream parser.
`include "protobuf_wire_stream_parser_assert.svh"

module pwsp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  pwsp_pkg::pwsp_in_t  item,
	output logic                have,
	output pwsp_pkg::pwsp_out_t result
);
	import pwsp_pkg::*;

	typedef enum logic [5:0] {
		PH_TAG     = 6'b000001,
		PH_VARINT  = 6'b000010,
		PH_FIX64   = 6'b000100,
		PH_FIX32   = 6'b001000,
		PH_LEN     = 6'b010000,
		PH_PAYLOAD = 6'b100000
	} pwsp_phase_t;

	typedef struct packed {
		pwsp_phase_t phase;
		logic [28:0] tag;
		logic [2:0]  wk;
		logic [63:0] val;
		logic [3:0]  pos;
		logic [31:0] left;
		logic        drop;
	} pwsp_state_t;

	localparam pwsp_state_t RESET_STATE = '{
		phase: PH_TAG, tag: '0, wk: '0, val: '0, pos: '0, left: '0, drop: 1'b0
	};

	pwsp_state_t st_q;
	pwsp_state_t upd;
	pwsp_state_t nx;

	logic [6:0]  d;
	logic        cont;
	logic        fin;
	logic [6:0]  sh7;
	logic [6:0]  tsh;
	logic [63:0] vsh;
	logic [63:0] fsh;
	logic [28:0] tadd;
	logic [63:0] acc;
	logic [2:0]  err;
	logic [1:0]  rkind;
	logic [63:0] rval;
	logic        hv;

	assign d    = item.in_byte[6:0];
	assign cont = item.in_byte[7];
	assign fin  = item.final_byte;
	// 7*pos, pos never exceeds nine
	assign sh7  = 7'({3'b000, st_q.pos} << 3) - 7'({3'b000, st_q.pos});
	assign tsh  = sh7 - 7'd3;
	assign vsh  = {57'b0, d} << sh7[5:0];
	assign fsh  = {56'b0, item.in_byte} << {st_q.pos[2:0], 3'b000};
	assign tadd = {22'b0, d} << tsh[4:0];
	assign acc  = st_q.val | vsh;

	always_comb begin
		upd   = st_q;
		err   = ERR_NONE;
		rkind = KIND_SCALAR;
		rval  = '0;
		hv    = 1'b0;
		unique case (st_q.phase)
			PH_VARINT: begin
				upd.val = acc;
				if (cont) begin
					if (st_q.pos >= VARINT_LAST_POS) err = ERR_TOO_LONG;
					else upd.pos = st_q.pos + 4'd1;
				end else begin
					hv        = 1'b1;
					rval      = acc;
					upd.phase = PH_TAG;
					upd.pos   = '0;
				end
			end
			PH_FIX64, PH_FIX32: begin
				upd.val = st_q.val | fsh;
				upd.pos = st_q.pos + 4'd1;
				if ((st_q.phase == PH_FIX64 && st_q.pos[2:0] == 3'd7) ||
						(st_q.phase == PH_FIX32 && st_q.pos[2:0] == 3'd3)) begin
					hv        = 1'b1;
					rval      = upd.val;
					upd.phase = PH_TAG;
					upd.pos   = '0;
				end
			end
			PH_LEN: begin
				if (st_q.pos >= LEN_DATA_POS && d != 7'd0) begin
					err = ERR_LEN_LARGE;
				end else begin
					upd.val = acc;
					if (acc[63:32] != 32'd0) begin
						err = ERR_LEN_LARGE;
					end else if (cont) begin
						if (st_q.pos >= VARINT_LAST_POS) err = ERR_TOO_LONG;
						else upd.pos = st_q.pos + 4'd1;
					end else begin
						hv        = 1'b1;
						rkind     = KIND_HEADER;
						rval      = acc;
						upd.left  = acc[31:0];
						upd.pos   = '0;
						upd.phase = (acc[31:0] != 32'd0) ? PH_PAYLOAD : PH_TAG;
					end
				end
			end
			PH_PAYLOAD: begin
				hv       = 1'b1;
				rkind    = KIND_PAYLOAD;
				rval     = {56'b0, item.in_byte};
				upd.left = st_q.left - 32'd1;
				if (st_q.left == 32'd1) upd.phase = PH_TAG;
			end
			PH_TAG: begin
				if (st_q.pos == 4'd0) begin
					upd.wk  = item.in_byte[2:0];
					upd.tag = {25'b0, item.in_byte[6:3]};
				end else begin
					upd.tag = st_q.tag | tadd;
				end
				if (cont) begin
					if (st_q.pos >= TAG_LAST_POS) err = ERR_TOO_LONG;
					else upd.pos = st_q.pos + 4'd1;
				end else begin
					upd.pos = '0;
					upd.val = '0;
					unique case (upd.wk)
						WIRE_VARINT:              upd.phase = PH_VARINT;
						WIRE_FIX64:               upd.phase = PH_FIX64;
						WIRE_LEN:                 upd.phase = PH_LEN;
						WIRE_FIX32:               upd.phase = PH_FIX32;
						WIRE_SGROUP, WIRE_EGROUP: err = ERR_GROUP;
						default:                  err = ERR_UNKNOWN;
					endcase
				end
			end
			default: upd = RESET_STATE;
		endcase
	end

	always_comb begin
		nx                   = upd;
		have                 = 1'b0;
		result.kind          = rkind;
		result.field_id      = upd.tag;
		result.wire_kind     = upd.wk;
		result.payload_value = rval;
		result.error_code    = ERR_NONE;
		result.message_end   = fin;
		if (st_q.drop) begin
			nx = fin ? RESET_STATE : st_q;
		end else if (err != ERR_NONE) begin
			have                 = 1'b1;
			result.kind          = KIND_ERROR;
			result.payload_value = '0;
			result.error_code    = err;
			nx.drop              = 1'b1;
			if (fin) nx = RESET_STATE;
		end else if (fin && (upd.phase != PH_TAG || upd.pos != 4'd0)) begin
			have                 = 1'b1;
			result.kind          = KIND_ERROR;
			result.payload_value = '0;
			result.error_code    = ERR_TRUNCATED;
			nx                   = RESET_STATE;
		end else begin
			have = hv;
			if (fin) nx = RESET_STATE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= RESET_STATE;
		end else if (step) begin
			st_q <= nx;
		end
	end

	`PWSP_ASSERT_NXT(a_final_clears, step && item.final_byte,
		st_q.phase == PH_TAG && st_q.pos == 4'd0 && !st_q.drop,
		"final beat did not return decoder to tag phase")
	`PWSP_ASSERT_IMP(a_payload_left, st_q.phase == PH_PAYLOAD, st_q.left != 32'd0,
		"payload phase with no bytes left")
	`PWSP_ASSERT_IMP(a_pos_range, 1'b1, st_q.pos <= VARINT_LAST_POS,
		"byte position out of range")

endmodule

>>> bench/tb_protobuf_wire_stream_parser.sv
// Self-checking bench for the protobuf wire stream parser: random messages, beat checks.
module tb_protobuf_wire_stream_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import pwsp_pkg::*;

	localparam int LIVE_BYTES  = 500;
	localparam int CYCLE_LIMIT = 500000;

	class field_decode_tracker;
		typedef enum logic [2:0] {
			ST_TAG, ST_VARINT, ST_FIX64, ST_FIX32, ST_LEN, ST_PAYLOAD
		} dec_state_t;

		dec_state_t  state;
		logic [28:0] tag_acc;
		logic [2:0]  wire_cur;
		logic [63:0] val_acc;
		logic [3:0]  pos;
		logic [31:0] left;
		bit          dropping;
		pwsp_out_t   pending_fields[$];
		int          fails;
		int          live_bytes;

		function new();
			clear();
			fails = 0;
			live_bytes = 0;
		endfunction

		function void clear();
			state = ST_TAG;
			tag_acc = '0;
			wire_cur = '0;
			val_acc = '0;
			pos = '0;
			left = '0;
			dropping = 0;
		endfunction

		function void decode_byte(pwsp_in_t it);
			logic [7:0]  b;
			logic [6:0]  d;
			logic [2:0]  err;
			logic [1:0]  rkind;
			logic [63:0] rval;
			logic [28:0] chunk;
			bit          have;
			bit          fin;
			pwsp_out_t   r;
			b = it.in_byte;
			fin = it.final_byte;
			d = b[6:0];
			err = ERR_NONE;
			rkind = KIND_SCALAR;
			rval = '0;
			have = 0;
			live_bytes++;
			if (dropping) begin
				if (fin)
					clear();
				return;
			end
			case (state)
			ST_VARINT: begin
				if (pos <= VARINT_LAST_POS)
					val_acc |= {57'd0, d} << (7 * pos);
				if (b[7]) begin
					if (pos >= VARINT_LAST_POS)
						err = ERR_TOO_LONG;
					else
						pos++;
				end else begin
					have = 1;
					rval = val_acc;
					state = ST_TAG;
					pos = 0;
				end
			end
			ST_FIX64, ST_FIX32: begin
				if (pos < 8)
					val_acc |= {56'd0, b} << (8 * pos);
				pos++;
				if (pos >= ((state == ST_FIX64) ? 8 : 4)) begin
					have = 1;
					rval = val_acc;
					state = ST_TAG;
					pos = 0;
				end
			end
			ST_LEN: begin
				if (pos >= LEN_DATA_POS && d != 0) begin
					err = ERR_LEN_LARGE;
				end else begin
					if (pos <= VARINT_LAST_POS)
						val_acc |= {57'd0, d} << (7 * pos);
					if (val_acc[63:32] != 0) begin
						err = ERR_LEN_LARGE;
					end else if (b[7]) begin
						if (pos >= VARINT_LAST_POS)
							err = ERR_TOO_LONG;
						else
							pos++;
					end else begin
						have = 1;
						rkind = KIND_HEADER;
						rval = val_acc;
						left = val_acc[31:0];
						pos = 0;
						state = (left != 0) ? ST_PAYLOAD : ST_TAG;
					end
				end
			end
			ST_PAYLOAD: begin
				have = 1;
				rkind = KIND_PAYLOAD;
				rval = {56'd0, b};
				if (left != 0)
					left--;
				if (left == 0)
					state = ST_TAG;
			end
			default: begin
				if (pos == 0) begin
					wire_cur = b[2:0];
					tag_acc = {25'd0, b[6:3]};
				end else if (pos <= TAG_LAST_POS) begin
					chunk = {22'd0, d};
					tag_acc |= chunk << (4 + 7 * (pos - 1));
				end
				if (b[7]) begin
					if (pos >= TAG_LAST_POS)
						err = ERR_TOO_LONG;
					else
						pos++;
				end else begin
					pos = 0;
					val_acc = '0;
					case (wire_cur)
					WIRE_VARINT: state = ST_VARINT;
					WIRE_FIX64: state = ST_FIX64;
					WIRE_LEN: state = ST_LEN;
					WIRE_FIX32: state = ST_FIX32;
					WIRE_SGROUP, WIRE_EGROUP: err = ERR_GROUP;
					default: err = ERR_UNKNOWN;
					endcase
				end
			end
			endcase

			r.field_id = tag_acc;
			r.wire_kind = wire_cur;
			r.message_end = fin;
			if (err != ERR_NONE) begin
				r.kind = KIND_ERROR;
				r.payload_value = '0;
				r.error_code = err;
				pending_fields.push_back(r);
				if (fin)
					clear();
				else
					dropping = 1;
			end else if (fin && (state != ST_TAG || pos != 0)) begin
				r.kind = KIND_ERROR;
				r.payload_value = '0;
				r.error_code = ERR_TRUNCATED;
				pending_fields.push_back(r);
				clear();
			end else begin
				if (have) begin
					r.kind = rkind;
					r.payload_value = rval;
					r.error_code = ERR_NONE;
					pending_fields.push_back(r);
				end
				if (fin)
					clear();
			end
		endfunction

		function void compare(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t %s: expected %0h, got %0h", $time, name, want, got);
				fails++;
			end
		endfunction

		function void check_field(pwsp_out_t got);
			pwsp_out_t want;
			if (pending_fields.size() == 0) begin
				$display("%0t unexpected beat: expected none, got %p", $time, got);
				fails++;
				return;
			end
			want = pending_fields.pop_front();
			compare("kind", 64'(want.kind), 64'(got.kind));
			compare("field_id", 64'(want.field_id), 64'(got.field_id));
			compare("wire_kind", 64'(want.wire_kind), 64'(got.wire_kind));
			compare("payload_value", want.payload_value, got.payload_value);
			compare("error_code", 64'(want.error_code), 64'(got.error_code));
			compare("message_end", 64'(want.message_end), 64'(got.message_end));
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      byte_valid;
	logic      byte_ready;
	pwsp_in_t  byte_data;
	logic      res_valid;
	logic      res_ready;
	pwsp_out_t res_data;

	field_decode_tracker tracker = new();
	logic [7:0]          msg_q[$];
	bit                  quiet;

	protobuf_wire_stream_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data)
	);

	always #5 clk = ~clk;

	function automatic int varint_len(logic [63:0] v);
		int n;
		for (n = 1; n < 10 && (v >> (7 * n)) != 0; n++);
		return n;
	endfunction

	task automatic push_varint(input logic [63:0] v, input int n);
		logic [7:0] octet;
		for (int i = 0; i < n; i++) begin
			octet = (i < 10) ? {1'b0, 7'(v >> (7 * i))} : 8'd0;
			if (i < n - 1)
				octet[7] = 1'b1;
			msg_q.push_back(octet);
		end
	endtask

	task automatic push_tag(input logic [28:0] fnum, input logic [2:0] wt, input bit too_long);
		logic [63:0] v;
		int          n;
		v = {32'd0, fnum, wt};
		n = varint_len(v);
		if (too_long)
			n = 6;
		else if ($urandom_range(0, 3) == 0)
			n = $urandom_range(n, 5);
		push_varint(v, n);
		// high bits of a fifth tag byte are discarded
		if (n == 5 && $urandom_range(0, 1))
			msg_q[msg_q.size() - 1][6:4] = 3'($urandom);
	endtask

	task automatic add_field();
		int          pick;
		int          n;
		int          sel;
		logic [28:0] fnum;
		logic [2:0]  wt;
		logic [63:0] v;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 4))
		0: fnum = '0;
		1: fnum = 29'd1;
		2: fnum = '1;
		3: fnum = 29'($urandom_range(2, 15));
		default: fnum = 29'($urandom);
		endcase
		if (pick < 4) begin
			repeat ($urandom_range(1, 4))
				msg_q.push_back(8'($urandom));
			return;
		end
		if (pick < 34)
			wt = WIRE_VARINT;
		else if (pick < 46)
			wt = WIRE_FIX64;
		else if (pick < 58)
			wt = WIRE_FIX32;
		else if (pick < 88)
			wt = WIRE_LEN;
		else if (pick < 92)
			wt = $urandom_range(0, 1) ? WIRE_SGROUP : WIRE_EGROUP;
		else
			wt = 3'($urandom_range(6, 7));
		push_tag(fnum, wt, pick >= 96);
		if (pick >= 88)
			return;
		case (wt)
		WIRE_VARINT: begin
			v = {$urandom, $urandom} >> $urandom_range(0, 63);
			if ($urandom_range(0, 9) == 0)
				v = '1;
			n = varint_len(v);
			if ($urandom_range(0, 15) == 0)
				n = 11;
			else if ($urandom_range(0, 3) == 0)
				n = $urandom_range(n, 10);
			push_varint(v, n);
		end
		WIRE_FIX64, WIRE_FIX32: begin
			repeat ((wt == WIRE_FIX64) ? 8 : 4)
				msg_q.push_back(8'($urandom));
		end
		default: begin
			sel = $urandom_range(0, 19);
			if (sel == 0) begin
				v = {$urandom, $urandom};
				v[32 + $urandom_range(0, 31)] = 1'b1;
				push_varint(v, varint_len(v));
			end else begin
				v = (sel == 1) ? 64'hFFFF_FFFF : 64'($urandom_range(0, 8));
				n = varint_len(v);
				if ($urandom_range(0, 3) == 0)
					n = $urandom_range(n, 10);
				push_varint(v, n);
				repeat ((sel == 1) ? 3 : int'(v))
					msg_q.push_back(8'($urandom));
			end
		end
		endcase
	endtask

	task automatic send_byte(input pwsp_in_t it);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_data <= it;
		byte_valid <= 1'b1;
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
		tracker.decode_byte(it);
		@(negedge clk);
	endtask

	task automatic send_message();
		pwsp_in_t it;
		for (int i = 0; i < msg_q.size(); i++) begin
			it.in_byte = msg_q[i];
			it.final_byte = (i == msg_q.size() - 1);
			send_byte(it);
		end
		msg_q.delete();
	endtask

	initial begin
		int stall;
		res_ready = 1'b0;
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			while (!res_valid)
				@(posedge clk);
			tracker.check_field(res_data);
			@(negedge clk);
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_protobuf_wire_stream_parser: FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_data = '0;
		quiet = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// header of length zero, then fixed32 closing the message
		msg_q = '{8'h0A, 8'h00, 8'h15, 8'hFF, 8'h00, 8'h80, 8'h7F};
		send_message();
		msg_q = '{8'h0B};
		send_message();
		// unknown type mid-message, final byte dropped
		msg_q = '{8'h0F, 8'h00};
		send_message();
		msg_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_message();
		// largest field number with junk in the fifth tag byte
		msg_q = '{8'hF8, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00};
		send_message();
		msg_q = '{8'h12, 8'h02, 8'hAB};
		send_message();
		msg_q = '{8'h0A, 8'h80, 8'h80, 8'h80, 8'h80, 8'h10};
		send_message();

		while (tracker.live_bytes < LIVE_BYTES) begin
			quiet = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(1, 4))
				add_field();
			if ($urandom_range(0, 6) == 0 && msg_q.size() > 1)
				repeat ($urandom_range(1, msg_q.size() - 1))
					void'(msg_q.pop_back());
			send_message();
		end
		byte_valid <= 1'b0;

		while (tracker.pending_fields.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.fails == 0 && tracker.pending_fields.size() == 0)
			$display("tb_protobuf_wire_stream_parser: PASS");
		else
			$display("tb_protobuf_wire_stream_parser: FAIL");
		$finish;
	end
endmodule
